// ----- hw/rtl/gshare_pkg.sv -----
// ----------------------------------------------------------------------------
// gshare_pkg
// Shared types and constants for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gshare_pkg;

	localparam int TABLE_INDEX_BITS = 10;
	localparam int HISTORY_WIDTH    = 16;
	localparam int TABLE_SIZE       = 1 << TABLE_INDEX_BITS;
	localparam int HIST_BITS_W      = 5;
	localparam int COUNT_W          = 32;

	localparam logic [HIST_BITS_W-1:0] HIST_BITS_RESET = 5'd10;
	localparam logic [1:0]             CTR_RESET       = 2'd1;
	localparam logic [1:0]             CTR_MAX         = 2'd3;
	localparam logic [1:0]             CTR_MIN         = 2'd0;
	localparam logic [COUNT_W-1:0]     COUNT_MAX       = 32'hffff_ffff;

	typedef struct packed {
		logic [31:0] branch_pc;
		logic        taken;
	} branch_req_t;

	typedef struct packed {
		logic               predicted_taken;
		logic               mispredicted;
		logic [COUNT_W-1:0] branch_count;
		logic [COUNT_W-1:0] taken_count;
		logic [COUNT_W-1:0] mispredict_count;
	} branch_rsp_t;

endpackage

// ----- hw/rtl/gshare_ram.sv -----
// ----------------------------------------------------------------------------
// gshare_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gshare_ram #(
	parameter  int WIDTH = 2,
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/gshare_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare direction predictor with 2-bit counters and saturating statistics.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one resolved branch per
//   request: its pc and its taken outcome. rsp channel (rsp_valid/rsp_ready/
//   rsp) returns one result per request, in order: the prediction made before
//   the update, the mispredict flag and the three running counts.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes hist_bits; it is always
//   ready and should be written only while no request is in flight.
//   The counter table is a RAM with a registered read, so the read is issued
//   when a request is taken and the counter update and write back happen in
//   the following stage, which also loads the result register.
//   Throughput is one request per cycle while the receiver does not stall;
//   a write back to the same entry as the next request is forwarded.
//   After reset a clearing pass writes every table entry to weakly not taken;
//   req_ready stays low during it. When the receiver stalls, the result
//   register holds, the compute stage holds behind it and req_ready drops.
// ----------------------------------------------------------------------------
module gshare_branch_predictor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  gshare_pkg::branch_req_t           req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output gshare_pkg::branch_rsp_t           rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gshare_pkg::HIST_BITS_W-1:0] cfg_data
);
	import gshare_pkg::*;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

	logic [HIST_BITS_W-1:0]      hist_bits_q;
	logic [HISTORY_WIDTH-1:0]    hist_q;
	logic [HIST_BITS_W:0]        hb_eff;
	logic [HISTORY_WIDTH-1:0]    hist_mask;
	logic [31:0]                 hist_ext;
	logic [TABLE_INDEX_BITS-1:0] idx_in;
	logic                        accept;

	logic                        clr_busy_q;
	logic [TABLE_INDEX_BITS-1:0] clr_addr_q;

	logic                        s1_valid;
	logic [TABLE_INDEX_BITS-1:0] idx_s1;
	logic                        taken_s1;
	logic                        fwd_s1;
	logic [1:0]                  fwd_ctr_s1;
	logic                        s1_move;

	logic [1:0]                  ram_rdata;
	logic                        ram_we;
	logic [TABLE_INDEX_BITS-1:0] ram_waddr;
	logic [1:0]                  ram_wdata;

	logic [1:0]                  ctr_cur;
	logic [1:0]                  ctr_new;
	logic                        pred;
	logic                        miss;

	logic [COUNT_W-1:0]          branches_q, taken_cnt_q, miss_cnt_q;
	logic [COUNT_W-1:0]          branches_nxt, taken_cnt_nxt, miss_cnt_nxt;

	logic                        rsp_valid_q;
	branch_rsp_t                 rsp_q;

	// history length clamps at the register width
	assign hb_eff = ({1'b0, hist_bits_q} > (HIST_BITS_W+1)'(HISTORY_WIDTH))
		? (HIST_BITS_W+1)'(HISTORY_WIDTH) : {1'b0, hist_bits_q};

	always_comb begin
		for (int i = 0; i < HISTORY_WIDTH; i++) begin
			hist_mask[i] = (i < int'(hb_eff));
		end
	end

	assign hist_ext = 32'(hist_q & hist_mask);
	assign idx_in   = TABLE_INDEX_BITS'((req.branch_pc >> 1) ^ hist_ext);

	assign s1_move   = s1_valid && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!s1_valid || s1_move);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;

	// compute stage
	assign ctr_cur = fwd_s1 ? fwd_ctr_s1 : ram_rdata;
	assign pred    = ctr_cur[1];
	assign miss    = pred ^ taken_s1;

	always_comb begin
		if (taken_s1) begin
			ctr_new = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 2'd1;
		end else begin
			ctr_new = (ctr_cur == CTR_MIN) ? ctr_cur : ctr_cur - 2'd1;
		end
	end

	assign branches_nxt  = sat_inc(branches_q);
	assign taken_cnt_nxt = taken_s1 ? sat_inc(taken_cnt_q) : taken_cnt_q;
	assign miss_cnt_nxt  = miss ? sat_inc(miss_cnt_q) : miss_cnt_q;

	assign ram_we    = clr_busy_q || s1_move;
	assign ram_waddr = clr_busy_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clr_busy_q ? CTR_RESET : ctr_new;

	gshare_ram #(
		.WIDTH(2),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(idx_in),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_bits_q <= HIST_BITS_RESET;
			hist_q      <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			s1_valid    <= 1'b0;
			branches_q  <= '0;
			taken_cnt_q <= '0;
			miss_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hist_bits_q <= cfg_data;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + TABLE_INDEX_BITS'(1);
				if (clr_addr_q == TABLE_INDEX_BITS'(TABLE_SIZE - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				hist_q   <= HISTORY_WIDTH'({hist_q, req.taken});
				s1_valid <= 1'b1;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end
			if (s1_move) begin
				branches_q  <= branches_nxt;
				taken_cnt_q <= taken_cnt_nxt;
				miss_cnt_q  <= miss_cnt_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= idx_in;
			taken_s1   <= req.taken;
			// the write back of the item ahead lands at this same edge
			fwd_s1     <= s1_move && (idx_s1 == idx_in);
			fwd_ctr_s1 <= ctr_new;
		end
		if (s1_move) begin
			rsp_q.predicted_taken  <= pred;
			rsp_q.mispredicted     <= miss;
			rsp_q.branch_count     <= branches_nxt;
			rsp_q.taken_count      <= taken_cnt_nxt;
			rsp_q.mispredict_count <= miss_cnt_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/gshare_checker.sv -----
// ----------------------------------------------------------------------------
// gshare_checker
// Port-level checks for the gshare branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module gshare_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_ready,
	input  gshare_pkg::branch_req_t           req,
	input  logic                              rsp_valid,
	input  logic                              rsp_ready,
	input  gshare_pkg::branch_rsp_t           rsp,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [gshare_pkg::HIST_BITS_W-1:0] cfg_data
);
	import gshare_pkg::*;

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without a request");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.branch_count >= rsp.taken_count
			&& rsp.branch_count >= rsp.mispredict_count && rsp.branch_count != '0)
		else $error("running counts inconsistent");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mispredicted |-> rsp.mispredict_count != '0)
		else $error("mispredict not counted");

	logic unused_ok;
	assign unused_ok = ^{req, cfg_valid, cfg_ready, cfg_data};

endmodule

bind gshare_branch_predictor gshare_checker u_gshare_checker (.*);

// ----- tb/gshare_branch_predictor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor_test
// Drives resolved branches into the predictor under random stalls on both
// channels, predicts every response with an in-bench table, history and
// running counts, and checks each response field by field in order.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_test;

	import gshare_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 212;
	localparam int POOL        = 12;

	localparam logic [HIST_BITS_W-1:0] PHASE_HIST [PHASES] = '{
		5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd10, 5'd8, 5'd0
	};

	typedef enum int {ALWAYS_TAKEN, NEVER_TAKEN, LOOP_EXIT, MOSTLY_TAKEN} habit_t;

	class branch_scoreboard;
		logic [1:0]               counters [TABLE_SIZE];
		logic [HISTORY_WIDTH-1:0] history;
		logic [HIST_BITS_W-1:0]   hist_bits;
		logic [COUNT_W-1:0]       branches;
		logic [COUNT_W-1:0]       takens;
		logic [COUNT_W-1:0]       misses;
		branch_rsp_t              pending [$];
		int                       errors;

		function new();
			foreach (counters[i]) counters[i] = CTR_RESET;
			history   = '0;
			hist_bits = HIST_BITS_RESET;
			branches  = '0;
			takens    = '0;
			misses    = '0;
			errors    = 0;
		endfunction

		function void set_hist_bits(logic [HIST_BITS_W-1:0] value);
			hist_bits = value;
		endfunction

		function void note_branch(branch_req_t r);
			int unsigned                 hb;
			logic [HISTORY_WIDTH-1:0]    hmask;
			logic [TABLE_INDEX_BITS-1:0] idx;
			logic [1:0]                  ctr;
			branch_rsp_t                 want;
			// lengths beyond the register width use the whole history
			hb    = (hist_bits > HISTORY_WIDTH) ? HISTORY_WIDTH : hist_bits;
			hmask = HISTORY_WIDTH'((64'd1 << hb) - 64'd1);
			idx   = TABLE_INDEX_BITS'(r.branch_pc[31:1] ^ (history & hmask));
			ctr   = counters[idx];
			want.predicted_taken = ctr[1];
			want.mispredicted    = ctr[1] != r.taken;
			if (branches != COUNT_MAX) branches++;
			if (r.taken && takens != COUNT_MAX) takens++;
			if (want.mispredicted && misses != COUNT_MAX) misses++;
			want.branch_count     = branches;
			want.taken_count      = takens;
			want.mispredict_count = misses;
			if (r.taken && ctr != CTR_MAX) begin
				ctr++;
			end else if (!r.taken && ctr != CTR_MIN) begin
				ctr--;
			end
			counters[idx] = ctr;
			history = {history[HISTORY_WIDTH-2:0], r.taken};
			pending.push_back(want);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(branch_rsp_t got);
			branch_rsp_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("response %h with no request pending", got));
			end else begin
				want = pending.pop_front();
				if (got.predicted_taken !== want.predicted_taken)
					report_mismatch($sformatf("predicted_taken got %0d expected %0d",
						got.predicted_taken, want.predicted_taken));
				if (got.mispredicted !== want.mispredicted)
					report_mismatch($sformatf("mispredicted got %0d expected %0d",
						got.mispredicted, want.mispredicted));
				if (got.branch_count !== want.branch_count)
					report_mismatch($sformatf("branch_count got %0d expected %0d",
						got.branch_count, want.branch_count));
				if (got.taken_count !== want.taken_count)
					report_mismatch($sformatf("taken_count got %0d expected %0d",
						got.taken_count, want.taken_count));
				if (got.mispredict_count !== want.mispredict_count)
					report_mismatch($sformatf("mispredict_count got %0d expected %0d",
						got.mispredict_count, want.mispredict_count));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	branch_req_t            req;
	logic                   rsp_valid;
	logic                   rsp_ready;
	branch_rsp_t            rsp;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [HIST_BITS_W-1:0] cfg_data;

	branch_scoreboard sb;
	bit               send_idle;
	bit               recv_idle;
	int               cycle_count;

	logic [31:0] pool_pc    [POOL];
	habit_t      pool_habit [POOL];
	int          pool_trip  [POOL];
	int          pool_len   [POOL];

	gshare_branch_predictor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// all driving tasks start and end on a falling edge
	task send_branch(input logic [31:0] pc, input logic tk);
		int gap;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.branch_pc <= pc;
		req.taken     <= tk;
		req_valid     <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_branch(req);
		@(negedge clk);
	endtask

	task drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_hist_bits(input logic [HIST_BITS_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_hist_bits(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task refill_pool();
		for (int k = 0; k < POOL; k++) begin
			pool_pc[k]    = $urandom;
			pool_habit[k] = habit_t'(k % 4);
			pool_len[k]   = $urandom_range(3, 9);
			pool_trip[k]  = pool_len[k];
		end
	endtask

	// mostly a small set of branches with steady habits so counters train,
	// the rest fully random addresses and outcomes
	function automatic branch_req_t next_branch();
		branch_req_t r;
		int          k;
		if ($urandom_range(0, 3) == 0) begin
			r.branch_pc = $urandom;
			r.taken     = 1'($urandom_range(0, 1));
		end else begin
			k = $urandom_range(0, POOL - 1);
			r.branch_pc = pool_pc[k];
			case (pool_habit[k])
				ALWAYS_TAKEN: r.taken = 1'b1;
				NEVER_TAKEN:  r.taken = 1'b0;
				LOOP_EXIT: begin
					if (pool_trip[k] == 0) begin
						r.taken      = 1'b0;
						pool_trip[k] = pool_len[k];
					end else begin
						r.taken = 1'b1;
						pool_trip[k]--;
					end
				end
				default: r.taken = $urandom_range(0, 9) < 7;
			endcase
		end
		return r;
	endfunction

	// response side
	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp);
			@(negedge clk);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [HIST_BITS_W-1:0] hv;
		branch_req_t            r;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// default history length, extreme and alternating addresses
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hffff_ffff, 1'b0);
		send_branch(32'h5555_5554, 1'b1);
		send_branch(32'haaaa_aaab, 1'b0);
		drain();

		// bimodal: walk one counter up past its top and down past its bottom
		write_hist_bits(5'd0);
		repeat (4) send_branch(32'h0000_0100, 1'b1);
		repeat (4) send_branch(32'h0000_0100, 1'b0);
		drain();

		// oversized history lengths behave as the full register
		write_hist_bits(5'd31);
		send_branch(32'h0000_2468, 1'b1);
		send_branch(32'h0000_2468, 1'b0);
		send_branch(32'h0000_2468, 1'b1);
		send_branch(32'hffff_ffff, 1'b1);
		drain();
		write_hist_bits(5'd16);
		for (int n = 0; n < 4; n++) send_branch(32'h8000_0000 | (n << 1), n[0]);
		drain();
		write_hist_bits(5'd17);
		send_branch(32'h0000_fffe, 1'b1);
		send_branch(32'h0001_0000, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			hv = (p == PHASES - 1) ? HIST_BITS_W'($urandom_range(0, 31)) : PHASE_HIST[p];
			write_hist_bits(hv);
			send_idle = (p % 3) != 1;
			recv_idle = (p % 4) != 2;
			refill_pool();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off new requests until the pipeline is empty
				if (p == 3 && n == PHASE_ITEMS / 2) drain();
				r = next_branch();
				send_branch(r.branch_pc, r.taken);
			end
		end
		drain();
		repeat (8) @(negedge clk);

		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
